// ===== sv/aisnm_pkg.sv =====
`timescale 1ns / 1ps
// aisnm_pkg: shared types, character codes and helper functions of the !AIVDM encoder
// depends on nothing; imported by every module of the block but aisnm_checker

package aisnm_pkg;

	localparam int MAX_MSG_BYTES_DEF = 128;
	localparam int BYTE_CNT_W        = 8;
	localparam int CMD_DEPTH         = 2;
	localparam int CMD_PTR_W         = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W         = $clog2(CMD_DEPTH + 1);

	localparam int ACC_W     = 12;
	localparam int HELD_W    = 4;
	localparam int GROUP_W   = 6;
	localparam int PREFIX_LEN = 12;

	localparam logic [7:0] CHANNEL_A_NUM = 8'd19;
	localparam logic [7:0] CHANNEL_RESET = 8'd19;

	localparam logic [6:0] CH_COMMA = 7'h2C;
	localparam logic [6:0] CH_STAR  = 7'h2A;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_A     = 7'h41;
	localparam logic [6:0] CH_B     = 7'h42;

	localparam logic [6:0] ARMOR_OFFSET = 7'd48;
	localparam logic [6:0] ARMOR_LIMIT  = 7'd87;
	localparam logic [6:0] ARMOR_SKIP   = 7'd8;

	// one queued item: what the back end has to do for it
	typedef struct packed {
		logic       open_sentence;
		logic       letter_a;
		logic       take;
		logic       last;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [6:0] prefix_char(input logic [3:0] idx);
		logic [6:0] c;
		unique case (idx)
			4'd0:    c = 7'h21; // '!'
			4'd1:    c = 7'h41; // 'A'
			4'd2:    c = 7'h49; // 'I'
			4'd3:    c = 7'h56; // 'V'
			4'd4:    c = 7'h44; // 'D'
			4'd5:    c = 7'h4D; // 'M'
			4'd7:    c = 7'h31; // '1'
			4'd9:    c = 7'h31; // '1'
			default: c = CH_COMMA;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] armor(input logic [5:0] v);
		logic [6:0] c;
		c = {1'b0, v} + ARMOR_OFFSET;
		if (c > ARMOR_LIMIT) begin
			c = c + ARMOR_SKIP;
		end
		return c;
	endfunction

	function automatic logic [6:0] hex_digit(input logic [3:0] v);
		logic [6:0] c;
		if (v < 4'd10) begin
			c = CH_ZERO + {3'b000, v};
		end else begin
			c = CH_A + {3'b000, v} - 7'd10;
		end
		return c;
	endfunction

endpackage

// ===== sv/aisnm_front.sv =====
`timescale 1ns / 1ps
// aisnm_front: accepts payload bytes, tracks sentence and byte count, queues commands
// depends on aisnm_pkg

module aisnm_front #(
	parameter int MAX_MSG_BYTES = aisnm_pkg::MAX_MSG_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              s_tlast,   // last_byte
	input  logic [7:0]        channel,
	input  logic              q_full,
	output logic              q_push,
	output aisnm_pkg::cmd_t   q_cmd
);
	import aisnm_pkg::*;

	logic                  open_q;
	logic [BYTE_CNT_W-1:0] taken_q;
	logic                  accept;
	logic                  take;
	logic                  drop;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign take     = !open_q || (taken_q < BYTE_CNT_W'(MAX_MSG_BYTES));
	// a byte past the limit that does not close the sentence causes nothing
	assign drop     = open_q && !take && !s_tlast;

	assign q_push             = accept && !drop;
	assign q_cmd.open_sentence = !open_q;
	assign q_cmd.letter_a     = (channel == CHANNEL_A_NUM);
	assign q_cmd.take         = take;
	assign q_cmd.last         = s_tlast;
	assign q_cmd.data         = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			taken_q <= '0;
		end else if (accept) begin
			open_q <= !s_tlast;
			if (s_tlast) begin
				taken_q <= '0;
			end else if (!open_q) begin
				taken_q <= BYTE_CNT_W'(1);
			end else if (take) begin
				taken_q <= taken_q + BYTE_CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/aisnm_cmd_fifo.sv =====
`timescale 1ns / 1ps
// aisnm_cmd_fifo: short command queue between front and back end, flip-flop storage
// depends on aisnm_pkg

module aisnm_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aisnm_pkg::cmd_t push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output aisnm_pkg::cmd_t head
);
	import aisnm_pkg::*;

	cmd_t                 entry_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full      = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
		return (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + CMD_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/aisnm_back.sv =====
`timescale 1ns / 1ps
// aisnm_back: character sequencer, six-bit grouping, armoring, checksum and output register
// depends on aisnm_pkg

module aisnm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  aisnm_pkg::cmd_t q_head,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // character, zero in bit 7
	output logic            m_tlast,   // run_last
	output logic [0:0]      m_tuser    // sentence_end
);
	import aisnm_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_PREFIX  = 9'b000000010,
		ST_PAYLOAD = 9'b000000100,
		ST_PAD     = 9'b000001000,
		ST_COMMA   = 9'b000010000,
		ST_FILL    = 9'b000100000,
		ST_STAR    = 9'b001000000,
		ST_HEX_HI  = 9'b010000000,
		ST_HEX_LO  = 9'b100000000
	} state_t;

	state_t            state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [HELD_W-1:0] held_q, held_d;
	logic [7:0]        sum_q, sum_d;
	logic [3:0]        idx_q, idx_d;

	logic              out_valid_q;
	logic [6:0]        out_char_q;
	logic              out_rl_q;
	logic              out_se_q;

	logic              slot_free;
	logic              emit;
	logic              sum_en;
	logic [6:0]        ch;
	logic              rl;
	logic              se;

	logic [HELD_W-1:0] grp_shift;
	logic [HELD_W-1:0] held_rem;
	logic [ACC_W-1:0]  grp_word;
	logic [ACC_W-1:0]  rem_mask;
	logic [2:0]        fill;
	logic [ACC_W-1:0]  pad_word;

	assign slot_free = !out_valid_q || m_tready;

	assign grp_shift = held_q - HELD_W'(GROUP_W);
	assign held_rem  = grp_shift;
	assign grp_word  = acc_q >> grp_shift;
	assign rem_mask  = (ACC_W'(1) << held_rem) - ACC_W'(1);
	// held is 0, 2 or 4 once the byte is grouped
	assign fill      = (held_q == '0) ? 3'd0 : 3'(GROUP_W - int'(held_q));
	assign pad_word  = acc_q << fill;

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		acc_d   = acc_q;
		held_d  = held_q;
		sum_d   = sum_q;
		idx_d   = idx_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		sum_en  = 1'b1;
		ch      = CH_COMMA;
		rl      = 1'b0;
		se      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					cmd_d = q_head;
					if (q_head.open_sentence) begin
						acc_d   = '0;
						held_d  = '0;
						sum_d   = '0;
						idx_d   = '0;
						state_d = ST_PREFIX;
					end else if (q_head.take) begin
						acc_d   = {acc_q[ACC_W-9:0], q_head.data};
						held_d  = held_q + HELD_W'(8);
						state_d = ST_PAYLOAD;
					end else begin
						state_d = (held_q != '0) ? ST_PAD : ST_COMMA;
					end
				end
			end
			ST_PREFIX: begin
				if (slot_free) begin
					emit   = 1'b1;
					sum_en = (idx_q != '0);
					if (idx_q < 4'(PREFIX_LEN)) begin
						ch = prefix_char(idx_q);
					end else if (idx_q == 4'(PREFIX_LEN)) begin
						ch = cmd_q.letter_a ? CH_A : CH_B;
					end else begin
						ch = CH_COMMA;
					end
					idx_d = idx_q + 4'd1;
					if (idx_q == 4'(PREFIX_LEN + 1)) begin
						// first byte of a sentence is always taken
						acc_d   = {acc_q[ACC_W-9:0], cmd_q.data};
						held_d  = held_q + HELD_W'(8);
						state_d = ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				if (slot_free) begin
					emit   = 1'b1;
					ch     = armor(grp_word[GROUP_W-1:0]);
					held_d = held_rem;
					acc_d  = acc_q & rem_mask;
					if (held_rem < HELD_W'(GROUP_W)) begin
						if (cmd_q.last) begin
							state_d = (held_rem != '0) ? ST_PAD : ST_COMMA;
						end else begin
							rl      = 1'b1;
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_PAD: begin
				if (slot_free) begin
					emit    = 1'b1;
					ch      = armor(pad_word[GROUP_W-1:0]);
					state_d = ST_COMMA;
				end
			end
			ST_COMMA: begin
				if (slot_free) begin
					emit    = 1'b1;
					ch      = CH_COMMA;
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (slot_free) begin
					emit    = 1'b1;
					ch      = CH_ZERO + {4'b0000, fill};
					state_d = ST_STAR;
				end
			end
			ST_STAR: begin
				if (slot_free) begin
					emit    = 1'b1;
					sum_en  = 1'b0;
					ch      = CH_STAR;
					state_d = ST_HEX_HI;
				end
			end
			ST_HEX_HI: begin
				if (slot_free) begin
					emit    = 1'b1;
					sum_en  = 1'b0;
					ch      = hex_digit(sum_q[7:4]);
					state_d = ST_HEX_LO;
				end
			end
			ST_HEX_LO: begin
				if (slot_free) begin
					emit    = 1'b1;
					sum_en  = 1'b0;
					ch      = hex_digit(sum_q[3:0]);
					rl      = 1'b1;
					se      = 1'b1;
					acc_d   = '0;
					held_d  = '0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (emit && sum_en) begin
			sum_d = sum_q ^ {1'b0, ch};
		end
		if (state_q == ST_HEX_LO && emit) begin
			sum_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			held_q      <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			held_q  <= held_d;
			sum_q   <= sum_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (emit) begin
			out_char_q <= ch;
			out_rl_q   <= rl;
			out_se_q   <= se;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_rl_q;
	assign m_tuser  = out_se_q;

endmodule

// ===== sv/ais_nmea_sentence_encoder_unit.sv =====
`timescale 1ns / 1ps
// ais_nmea_sentence_encoder_unit: top level of the AIS payload to !AIVDM sentence encoder
// depends on aisnm_pkg, aisnm_front, aisnm_cmd_fifo, aisnm_back

// Takes decoded AIS payload bytes one item at a time on the slave stream (s_tlast marks the
// final byte of a message) and streams out the ASCII characters of one single-part !AIVDM
// sentence on the master stream. The first byte of a sentence adds the prefix
// "!AIVDM,1,1,,X," where X is A when the channel register holds 19 and B otherwise; the
// letter is sampled when that first byte is accepted. Payload bits are cut MSB first into
// six-bit groups and armored; the last byte adds the zero-padded remainder, then
// ",<fill>*" and two hex digits of the XOR checksum. m_tlast marks the last character caused
// by an input byte, m_tuser[0] the final checksum digit. Bytes past MAX_MSG_BYTES in one
// sentence are dropped without output (a dropped byte with s_tlast still closes the
// sentence). Flow: the front end accepts each byte into a two-entry command queue, so
// input keeps flowing while characters are still going out, until the queue is full.
// The back-end sequencer takes a command from the queue in its idle state and then
// emits its n characters one after another (n is 1 to 21; 21 for a single-byte
// sentence, 1 or 2 for a byte in the middle). A character waits in the output register
// while the sequencer is stalled by m_tready. The user writes the channel register with
// cfg_we/cfg_wdata only while the block is idle; the block itself does not enforce this.

module ais_nmea_sentence_encoder_unit #(
	parameter int MAX_MSG_BYTES = aisnm_pkg::MAX_MSG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// payload byte stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_byte
	// sentence character stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] character, [7] zero
	output logic       m_tlast,   // run_last
	output logic [0:0] m_tuser,   // [0] sentence_end
	// channel register write
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import aisnm_pkg::*;

	// receive channel number, decides the channel letter
	logic [7:0] channel_q;

	// command queue between front and back
	logic       q_push;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	cmd_t       q_push_cmd;
	cmd_t       q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_RESET;
		end else if (cfg_we) begin
			channel_q <= cfg_wdata;
		end
	end

	// front: sentence open flag and byte count, drops bytes past the limit
	aisnm_front #(
		.MAX_MSG_BYTES(MAX_MSG_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.channel (channel_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (q_push_cmd)
	);

	aisnm_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_valid),
		.head     (q_head)
	);

	// back: one character per cycle into the output register while m_tready does not stall it
	aisnm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// ===== sv/aisnm_checker.sv =====
`timescale 1ns / 1ps
// aisnm_checker: port-level assertions for the !AIVDM encoder, bound to the top level
// depends on ais_nmea_sentence_encoder_unit port names

module aisnm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [0:0] m_tuser
);

	// the final checksum digit always ends the run of its byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("sentence end without run last");

	// the final character is an uppercase hex digit
	a_end_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata >= 8'h30 && m_tdata <= 8'h39) || (m_tdata >= 8'h41 && m_tdata <= 8'h46))
		else $error("checksum digit is not hex");

	// only 7-bit characters come out
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("character above 7 bits");

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output changed while stalled");

endmodule

bind ais_nmea_sentence_encoder_unit aisnm_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);
